// ===== rtl/core/tlsu_pkg.sv =====
// shared types and constants of the thumb load/store unit
package tlsu_pkg;

  typedef enum logic [1:0] {
    REQ_EXEC = 2'd0,
    REQ_DATA = 2'd1,
    REQ_WREG = 2'd2,
    REQ_RREG = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_REG   = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_REJ   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    WAIT_NONE  = 2'd0,
    WAIT_LOAD  = 2'd1,
    WAIT_POP   = 2'd2,
    WAIT_MULTI = 2'd3
  } wait_t;

  // form codes of the thumb load/store decoder
  localparam logic [2:0] FORM_REG = 3'd0;
  localparam logic [2:0] FORM_SH  = 3'd1;
  localparam logic [2:0] FORM_IMM = 3'd2;
  localparam logic [2:0] FORM_HI  = 3'd3;
  localparam logic [2:0] FORM_SP  = 3'd4;
  localparam logic [2:0] FORM_PC  = 3'd5;
  localparam logic [2:0] FORM_PP  = 3'd6;
  localparam logic [2:0] FORM_MUL = 3'd7;

  localparam logic [2:0] EXT_B  = 3'd0;
  localparam logic [2:0] EXT_H  = 3'd1;
  localparam logic [2:0] EXT_W  = 3'd2;
  localparam logic [2:0] EXT_SB = 3'd3;
  localparam logic [2:0] EXT_SH = 3'd4;

  localparam logic [1:0] SIZE_B = 2'd0;
  localparam logic [1:0] SIZE_H = 2'd1;
  localparam logic [1:0] SIZE_W = 2'd2;

  localparam logic [3:0] IDX_SP = 4'd8;
  localparam logic [3:0] IDX_LR = 4'd9;
  localparam logic [3:0] IDX_PC = 4'd10;

  localparam logic [31:0] WORD_STEP = 32'd4;

  // result word leaving the sequencer
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [1:0]  size;
    logic [31:0] wdata;
    logic [31:0] rdata;
    logic        flush;
    logic        last;
  } res_t;

  // operation of the shared adder
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } add_op_t;

endpackage

// ===== rtl/core/thumb_load_store_unit.sv =====
// thumb load/store unit: sequencer, register file and shared address adder
// an input word is taken only in idle and is answered by a result word; a push or store
//   multiple walks its stores one by one, each by an adder pass, a wait for the output
//   register and a hand-off; a new input word may be taken while the last result still
//   waits in the output register
// the single shared adder computes every base and stack pointer update and single-access address
// synchronous active-low reset clears register file, sp, lr, pc and pending-load state
module thumb_load_store_unit
  import tlsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // form[2:0] opcode[18:3] load_data[50:19] reg_index[54:51] reg_value[86:55]
  input  logic [87:0] in_tdata,
  // req_type[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // mem_addr[31:0] mem_size[33:32] write_data[65:34] reg_data[97:66] flush[98]
  output logic [103:0] out_tdata,
  // out_kind[2:0]
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT,
    ST_WALK,
    ST_WAITOUT
  } state_t;

  state_t state_r;

  logic [31:0] regs_r [8];
  logic [31:0] sp_r, lr_r, pc_r;
  wait_t       wait_r;
  logic [2:0]  dest_r, ext_r, base_r;
  logic [8:0]  left_r;

  // captured input word
  req_t        req_r;
  logic [2:0]  form_r;
  logic [15:0] op_r;
  logic [31:0] data_r;
  logic [3:0]  idx_r;
  logic [31:0] val_r;

  // walk state for push / store multiple
  logic [8:0]  walk_r;
  logic        any_r;
  res_t        res_r;

  add_op_t     aop;
  logic [31:0] asum;
  logic        ofull, opush;
  res_t        odout;

  tlsu_adder u_add (.op(aop), .sum(asum));
  tlsu_out_reg u_out (
    .clk(clk), .rst_n(rst_n), .push(opush), .din(res_r), .full(ofull),
    .pop(out_tvalid & out_tready), .dout(odout)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ofull;
  assign out_tdata  = {5'b0, odout.flush, odout.rdata, odout.wdata, odout.size,
                       odout.addr};
  assign out_tuser  = odout.kind;
  assign out_tlast  = odout.last;
  assign opush      = (state_r == ST_EMIT) && !ofull;

  // opcode fields
  logic [2:0] f_r0, f_r3, f_r6, f_r8;
  logic       f_b10, f_ld;
  logic [4:0] f_off5;
  logic [8:0] pop_list;
  assign f_r0   = op_r[2:0];
  assign f_r3   = op_r[5:3];
  assign f_r6   = op_r[8:6];
  assign f_r8   = op_r[10:8];
  assign f_b10  = op_r[10];
  assign f_ld   = op_r[11];
  assign f_off5 = op_r[10:6];
  assign pop_list = {op_r[8], op_r[7:0]};

  // lowest set bit of a nine-bit list
  function automatic logic [3:0] lowest9(input logic [8:0] l);
    logic [3:0] r;
    r = 4'd9;
    for (int i = 8; i >= 0; i--) begin
      if (l[i]) r = 4'(i);
    end
    return r;
  endfunction

  // highest set bit (push walks from the top)
  function automatic logic [3:0] highest9(input logic [8:0] l);
    logic [3:0] r;
    r = 4'd9;
    for (int i = 0; i < 9; i++) begin
      if (l[i]) r = 4'(i);
    end
    return r;
  endfunction

  function automatic logic [31:0] ext_data(input logic [2:0] e, input logic [31:0] d);
    logic [31:0] r;
    unique case (e)
      EXT_B:   r = {24'd0, d[7:0]};
      EXT_H:   r = {16'd0, d[15:0]};
      EXT_SB:  r = {{24{d[7]}}, d[7:0]};
      EXT_SH:  r = {{16{d[15]}}, d[15:0]};
      default: r = d;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] mask_w(input logic [1:0] s, input logic [31:0] d);
    logic [31:0] r;
    unique case (s)
      SIZE_B:  r = {24'd0, d[7:0]};
      SIZE_H:  r = {16'd0, d[15:0]};
      default: r = d;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] ext_size(input logic [2:0] e);
    logic [1:0] r;
    if (e == EXT_B || e == EXT_SB) r = SIZE_B;
    else if (e == EXT_H || e == EXT_SH) r = SIZE_H;
    else r = SIZE_W;
    return r;
  endfunction

  // decode: adder operands, load flag, extend and reg of single accesses; adder operands of push, pop, multiple
  logic        s_load;
  logic [2:0]  s_ext, s_reg;
  logic [3:0]  walk_i, pop_i, mul_i;
  logic [8:0]  pend_mask;

  always_comb begin
    aop    = '{a: regs_r[f_r3], b: regs_r[f_r6], sub: 1'b0};
    s_load = f_ld;
    s_ext  = f_b10 ? EXT_B : EXT_W;
    s_reg  = f_r0;
    unique case (form_r)
      FORM_REG: begin
      end
      FORM_SH: begin
        s_load = f_b10 | f_ld;
        s_ext  = f_b10 ? (f_ld ? EXT_SH : EXT_SB) : EXT_H;
      end
      FORM_IMM: begin
        if (op_r[12]) begin
          aop.b = {27'd0, f_off5};
          s_ext = EXT_B;
        end else begin
          aop.b = {25'd0, f_off5, 2'b0};
          s_ext = EXT_W;
        end
      end
      FORM_HI: begin
        aop.b = {26'd0, f_off5, 1'b0};
        s_ext = EXT_H;
      end
      FORM_SP: begin
        aop   = '{a: sp_r, b: {22'd0, op_r[7:0], 2'b0}, sub: 1'b0};
        s_ext = EXT_W;
        s_reg = f_r8;
      end
      FORM_PC: begin
        aop    = '{a: {pc_r[31:2], 2'b0}, b: {22'd0, op_r[7:0], 2'b0}, sub: 1'b0};
        s_load = 1'b1;
        s_ext  = EXT_W;
        s_reg  = f_r8;
      end
      FORM_PP: aop = '{a: sp_r, b: WORD_STEP, sub: 1'b1};
      default: aop = '{a: regs_r[f_r8], b: WORD_STEP, sub: 1'b0};
    endcase
    // data return: pop advances sp, multiple advances base
    if (state_r == ST_CALC && req_r == REQ_DATA) begin
      if (wait_r == WAIT_POP) aop = '{a: sp_r, b: WORD_STEP, sub: 1'b0};
      else if (pop_i[2:0] == base_r) aop = '{a: data_r, b: WORD_STEP, sub: 1'b0};
      else aop = '{a: regs_r[base_r], b: WORD_STEP, sub: 1'b0};
    end
  end

  assign walk_i    = (form_r == FORM_PP) ? highest9(walk_r) : lowest9(walk_r);
  assign pend_mask = (wait_r == WAIT_POP) ? left_r : {1'b0, left_r[7:0]};
  assign pop_i     = lowest9(pend_mask);
  assign mul_i     = pop_i;

  function automatic res_t mk(input logic [2:0] k, input logic [31:0] a,
                              input logic [1:0] s, input logic [31:0] w,
                              input logic [31:0] r, input logic f, input logic l);
    res_t x;
    x = '{kind: k, addr: a, size: s, wdata: mask_w(s, w), rdata: r, flush: f, last: l};
    return x;
  endfunction

  logic [31:0] walk_val;
  assign walk_val = (walk_i == 4'd8) ? lr_r : regs_r[walk_i[2:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < 8; i++) regs_r[i] <= '0;
      sp_r   <= '0;
      lr_r   <= '0;
      pc_r   <= '0;
      wait_r <= WAIT_NONE;
      dest_r <= '0;
      ext_r  <= '0;
      left_r <= '0;
      base_r <= '0;
      walk_r <= '0;
      any_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            req_r  <= req_t'(in_tuser);
            form_r <= in_tdata[2:0];
            op_r   <= in_tdata[18:3];
            data_r <= in_tdata[50:19];
            idx_r  <= in_tdata[54:51];
            val_r  <= in_tdata[86:55];
            state_r <= ST_CALC;
          end
        end
        ST_CALC: begin
          // stores of push and store multiple are walked one by one
          state_r <= (req_r == REQ_EXEC && wait_r == WAIT_NONE && !f_ld &&
                      (form_r == FORM_PP || form_r == FORM_MUL)) ? ST_WALK : ST_EMIT;
          unique case (req_r)
            REQ_WREG: begin
              if (idx_r < 4'd8) regs_r[idx_r[2:0]] <= val_r;
              else if (idx_r == IDX_SP) sp_r <= val_r;
              else if (idx_r == IDX_LR) lr_r <= val_r;
              else if (idx_r == IDX_PC) pc_r <= val_r;
              res_r <= mk(KIND_DONE, '0, SIZE_B, '0, '0, 1'b0, 1'b1);
            end
            REQ_RREG: begin
              res_r <= mk(KIND_REG, '0, SIZE_B, '0,
                          (idx_r < 4'd8) ? regs_r[idx_r[2:0]] :
                          (idx_r == IDX_SP) ? sp_r : (idx_r == IDX_LR) ? lr_r :
                          (idx_r == IDX_PC) ? pc_r : '0, 1'b0, 1'b1);
            end
            REQ_DATA: begin
              if (wait_r == WAIT_LOAD) begin
                regs_r[dest_r] <= ext_data(ext_r, data_r);
                wait_r <= WAIT_NONE;
                res_r <= mk(KIND_DONE, '0, SIZE_B, '0, ext_data(ext_r, data_r), 1'b0, 1'b1);
              end else if (wait_r == WAIT_NONE) begin
                res_r <= mk(KIND_REJ, '0, SIZE_B, '0, '0, 1'b0, 1'b1);
              end else if (pop_i == 4'd9) begin
                wait_r <= WAIT_NONE;
                left_r <= '0;
                res_r <= mk(KIND_DONE, '0, SIZE_B, '0, '0, 1'b0, 1'b1);
              end else begin
                if (wait_r == WAIT_POP) begin
                  if (pop_i == 4'd8) pc_r <= data_r;
                  else regs_r[pop_i[2:0]] <= data_r;
                  sp_r <= asum;
                end else begin
                  // base in the list: the adder already holds loaded value plus four
                  if (mul_i[2:0] != base_r) regs_r[mul_i[2:0]] <= data_r;
                  regs_r[base_r] <= asum;
                end
                left_r <= left_r & ~(9'd1 << pop_i);
                if ((left_r & ~(9'd1 << pop_i)) != 9'd0) begin
                  res_r <= mk(KIND_READ, asum, SIZE_W, '0, '0, 1'b0, 1'b1);
                end else begin
                  wait_r <= WAIT_NONE;
                  res_r <= mk(KIND_DONE, '0, SIZE_B, '0, data_r, pop_i == 4'd8, 1'b1);
                end
              end
            end
            default: begin
              if (wait_r != WAIT_NONE) begin
                res_r <= mk(KIND_REJ, '0, SIZE_B, '0, '0, 1'b0, 1'b1);
              end else if (form_r == FORM_PP || form_r == FORM_MUL) begin
                if (f_ld) begin
                  if ((form_r == FORM_PP ? pop_list : {1'b0, op_r[7:0]}) == 9'd0) begin
                    res_r <= mk(KIND_DONE, '0, SIZE_B, '0, '0, 1'b0, 1'b1);
                  end else begin
                    wait_r <= (form_r == FORM_PP) ? WAIT_POP : WAIT_MULTI;
                    left_r <= (form_r == FORM_PP) ? pop_list : {1'b0, op_r[7:0]};
                    base_r <= f_r8;
                    res_r <= mk(KIND_READ, (form_r == FORM_PP) ? sp_r : regs_r[f_r8],
                                SIZE_W, '0, '0, 1'b0, 1'b1);
                  end
                end else begin
                  walk_r  <= (form_r == FORM_PP) ? pop_list : {1'b0, op_r[7:0]};
                  any_r   <= 1'b0;
                end
              end else if (s_load) begin
                wait_r <= WAIT_LOAD;
                dest_r <= s_reg;
                ext_r  <= s_ext;
                res_r <= mk(KIND_READ, asum, ext_size(s_ext), '0, '0, 1'b0, 1'b1);
              end else begin
                res_r <= mk(KIND_WRITE, asum, ext_size(s_ext), regs_r[s_reg],
                            '0, 1'b0, 1'b1);
              end
            end
          endcase
        end
        ST_WALK: begin
          // one store per pass through the adder
          if (walk_r == 9'd0) begin
            if (!any_r) begin
              res_r <= mk(KIND_DONE, '0, SIZE_B, '0, '0, 1'b0, 1'b1);
              state_r <= ST_EMIT;
            end else begin
              state_r <= ST_IDLE;
            end
          end else begin
            walk_r <= walk_r & ~(9'd1 << walk_i);
            any_r  <= 1'b1;
            if (form_r == FORM_PP) begin
              sp_r  <= asum;
              res_r <= mk(KIND_WRITE, asum, SIZE_W, walk_val, '0, 1'b0,
                          (walk_r & ~(9'd1 << walk_i)) == 9'd0);
            end else begin
              regs_r[f_r8] <= asum;
              res_r <= mk(KIND_WRITE, regs_r[f_r8], SIZE_W, walk_val, '0, 1'b0,
                          (walk_r & ~(9'd1 << walk_i)) == 9'd0);
            end
            state_r <= ST_WAITOUT;
          end
        end
        ST_WAITOUT: begin
          if (!ofull) state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!ofull) state_r <= (walk_r != 9'd0) ? ST_WALK : ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
      if (state_r == ST_EMIT && !ofull && walk_r == 9'd0) walk_r <= '0;
    end
  end

endmodule

// ===== rtl/core/tlsu_adder.sv =====
// shared 32-bit address adder/subtractor
module tlsu_adder
  import tlsu_pkg::*;
(
  input  add_op_t     op,
  output logic [31:0] sum
);
  assign sum = op.sub ? (op.a - op.b) : (op.a + op.b);
endmodule

// ===== rtl/core/tlsu_out_reg.sv =====
// output register that holds one result word until taken
module tlsu_out_reg
  import tlsu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t din,
  output logic full,
  input  logic pop,
  output res_t dout
);
  logic full_r;
  res_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (push) begin
      full_r <= 1'b1;
    end else if (pop) begin
      full_r <= 1'b0;
    end
    if (push) begin
      data_r <= din;
    end
  end

  assign full = full_r;
  assign dout = data_r;
endmodule
